### hdl/ctch_pkg.sv
// ----------------------------------------------------------------------------
// ctch_pkg
// Shared types and constants for the capacitive touch charge timer.
// ----------------------------------------------------------------------------
package ctch_pkg;

	localparam int unsigned TOTAL_WIDTH_DEF = 28;
	localparam int unsigned MS_WIDTH_DEF    = 32;

	localparam int unsigned VALUE_W   = 28;
	localparam int unsigned CFG_W     = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEED    = 2'd3;

	localparam logic [7:0]  SAMPLES_RST  = 8'd50;
	localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
	localparam logic [31:0] INTERVAL_RST = 32'd20000;
	localparam logic [15:0] BLEED_RST    = 16'd80;

	typedef struct packed {
		logic receive_level;
		logic ms_strobe;
	} ctch_in_t;

	typedef struct packed {
		logic               send_drive;
		logic               receive_drive_enable;
		logic               receive_drive_level;
		logic               reading_valid;
		logic               reading_error;
		logic [VALUE_W-1:0] reading_value;
	} ctch_out_t;

endpackage

### hdl/ctch_baseline.sv
// ----------------------------------------------------------------------------
// ctch_baseline
// Baseline tracking with autocalibration; gives the reading above baseline.
// ----------------------------------------------------------------------------
module ctch_baseline #(
	parameter int unsigned TOTAL_WIDTH = ctch_pkg::TOTAL_WIDTH_DEF,
	parameter int unsigned MS_WIDTH    = ctch_pkg::MS_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   done,
	input  logic [TOTAL_WIDTH-1:0] total,
	input  logic [MS_WIDTH-1:0]    ms_now,
	input  logic [31:0]            interval,
	output logic [TOTAL_WIDTH-1:0] value
);
	import ctch_pkg::*;

	localparam int unsigned DIV_SHIFT = TOTAL_WIDTH + 4;
	localparam int unsigned QUOT_W    = TOTAL_WIDTH - 3;
	localparam logic [TOTAL_WIDTH:0] DIV_MULT =
		(TOTAL_WIDTH+1)'(((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10);
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
	localparam logic [QUOT_W-1:0] DIV10_RST =
		QUOT_W'(((64'd1 << TOTAL_WIDTH) - 64'd1) / 64'd10);

	logic [TOTAL_WIDTH-1:0]   baseline_q;
	logic [MS_WIDTH-1:0]      last_cal_q;
	logic [QUOT_W-1:0]        div10_q;
	logic [2*TOTAL_WIDTH:0]   prod;
	logic [MS_WIDTH-1:0]      elapsed;
	logic [TOTAL_WIDTH-1:0]   diff;
	logic                     cal;
	logic [TOTAL_WIDTH-1:0]   base_eff;
	logic [TOTAL_WIDTH-1:0]   base_new;

	// The quotient is refreshed every cycle.
	assign prod = (2*TOTAL_WIDTH+1)'(baseline_q) * (2*TOTAL_WIDTH+1)'(DIV_MULT);

	always_comb begin
		elapsed  = ms_now - last_cal_q;
		diff     = (total > baseline_q) ? (total - baseline_q) : (baseline_q - total);
		cal      = (32'(elapsed) > interval) && (diff < {3'b000, div10_q});
		base_eff = cal ? TOTAL_MAX : baseline_q;
		base_new = (total < base_eff) ? total : base_eff;
		value    = total - base_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= TOTAL_MAX;
			last_cal_q <= '0;
			div10_q    <= DIV10_RST;
		end else begin
			div10_q <= prod[DIV_SHIFT +: QUOT_W];
			if (done) begin
				baseline_q <= base_new;
				if (cal) begin
					last_cal_q <= ms_now;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_base_not_above_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> baseline_q <= $past(total))
		else $error("baseline above the completed total");
	a_base_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(baseline_q) && $stable(last_cal_q))
		else $error("baseline changed without a completed reading");
	a_value_not_above_total: assert property (@(posedge clk) disable iff (!arst_n)
		value <= total)
		else $error("reported value above the total");
`endif

endmodule

### hdl/cap_touch_charge_timer_baseline_core.sv
// ----------------------------------------------------------------------------
// cap_touch_charge_timer_baseline_core
// Capacitive touch front end timing charge and discharge of a sense pin.
// ----------------------------------------------------------------------------
// Each input beat is one tick: the block takes one beat per clock and returns
// exactly one result beat per input beat, in the cycle after acceptance, by
// a single result register. The phase logic (bleed, charge wait, top-up,
// discharge wait) runs between the state registers and that result register,
// so the rate is one tick per cycle for as long as the output is not stalled.
// Pin drive fields reflect the phase at the start of the tick. A reading is
// the tick count summed over samples_per_reading senses; the reported value
// is that total minus the least total since recalibration, and a wait over
// detect_timeout_ms milliseconds reports an error and restarts the reading.
module cap_touch_charge_timer_baseline_core #(
	parameter int unsigned TOTAL_WIDTH = ctch_pkg::TOTAL_WIDTH_DEF,
	parameter int unsigned MS_WIDTH    = ctch_pkg::MS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ctch_pkg::ctch_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ctch_pkg::ctch_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [ctch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctch_pkg::CFG_W-1:0]      cfg_data
);
	import ctch_pkg::*;

	localparam logic [1:0] PH_BLEED     = 2'd0;
	localparam logic [1:0] PH_CHARGE    = 2'd1;
	localparam logic [1:0] PH_TOPUP     = 2'd2;
	localparam logic [1:0] PH_DISCHARGE = 2'd3;

	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

	logic [7:0]             samples_q;
	logic [15:0]            timeout_q;
	logic [31:0]            interval_q;
	logic [15:0]            bleed_ticks_q;

	logic [1:0]             phase_q, phase_d;
	logic [15:0]            bleed_cnt_q, bleed_cnt_d;
	logic [7:0]             sense_idx_q, sense_idx_d;
	logic [TOTAL_WIDTH-1:0] total_q, total_d;
	logic [MS_WIDTH-1:0]    ms_q, ms_next;
	logic [MS_WIDTH-1:0]    phase_start_q, phase_start_d;

	logic                   accept;
	logic [MS_WIDTH-1:0]    tdelta;
	logic                   timed_out;
	logic [TOTAL_WIDTH-1:0] total_inc;
	logic                   bleed_done;
	logic                   last_sense;
	logic                   done;
	logic [TOTAL_WIDTH-1:0] value_w;
	logic [31:0]            value_ext;
	ctch_out_t              res;
	ctch_out_t              out_q;
	logic                   out_valid_q;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q     <= SAMPLES_RST;
			timeout_q     <= TIMEOUT_RST;
			interval_q    <= INTERVAL_RST;
			bleed_ticks_q <= BLEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLES:  samples_q     <= cfg_data[7:0];
				CFG_TIMEOUT:  timeout_q     <= cfg_data[15:0];
				CFG_INTERVAL: interval_q    <= cfg_data[31:0];
				CFG_BLEED:    bleed_ticks_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ms_next    = ms_q + MS_WIDTH'(in_data.ms_strobe);
		tdelta     = ms_next - phase_start_q - MS_WIDTH'(timeout_q);
		timed_out  = (tdelta != '0) && !tdelta[MS_WIDTH-1];
		total_inc  = (total_q == TOTAL_MAX) ? total_q : (total_q + TOTAL_WIDTH'(1));
		bleed_done = ({1'b0, bleed_cnt_q} + 17'd1) >= {1'b0, bleed_ticks_q};
		last_sense = ({1'b0, sense_idx_q} + 9'd1) >= {1'b0, samples_q};
	end

	always_comb begin
		phase_d       = phase_q;
		bleed_cnt_d   = bleed_cnt_q;
		sense_idx_d   = sense_idx_q;
		total_d       = total_q;
		phase_start_d = phase_start_q;
		done          = 1'b0;
		res           = '0;
		case (phase_q)
			PH_CHARGE: begin
				res.send_drive = 1'b1;
				if (timed_out) begin
					res.reading_valid = 1'b1;
					res.reading_error = 1'b1;
					phase_d     = PH_BLEED;
					bleed_cnt_d = '0;
					sense_idx_d = '0;
					total_d     = '0;
				end else if (!in_data.receive_level) begin
					total_d = total_inc;
				end else begin
					phase_d = PH_TOPUP;
				end
			end
			PH_TOPUP: begin
				res.send_drive           = 1'b1;
				res.receive_drive_enable = 1'b1;
				res.receive_drive_level  = 1'b1;
				phase_d       = PH_DISCHARGE;
				phase_start_d = ms_next;
			end
			PH_DISCHARGE: begin
				if (timed_out) begin
					res.reading_valid = 1'b1;
					res.reading_error = 1'b1;
					phase_d     = PH_BLEED;
					bleed_cnt_d = '0;
					sense_idx_d = '0;
					total_d     = '0;
				end else if (in_data.receive_level) begin
					total_d = total_inc;
				end else if (last_sense) begin
					done              = 1'b1;
					res.reading_valid = 1'b1;
					res.reading_value = value_ext[VALUE_W-1:0];
					phase_d     = PH_BLEED;
					bleed_cnt_d = '0;
					sense_idx_d = '0;
					total_d     = '0;
				end else begin
					sense_idx_d = sense_idx_q + 8'd1;
					phase_d     = PH_BLEED;
					bleed_cnt_d = '0;
				end
			end
			default: begin
				res.receive_drive_enable = 1'b1;
				if (bleed_done) begin
					bleed_cnt_d   = '0;
					phase_d       = PH_CHARGE;
					phase_start_d = ms_next;
				end else begin
					bleed_cnt_d = bleed_cnt_q + 16'd1;
				end
			end
		endcase
	end

	ctch_baseline #(
		.TOTAL_WIDTH(TOTAL_WIDTH),
		.MS_WIDTH   (MS_WIDTH)
	) u_baseline (
		.clk     (clk),
		.arst_n  (arst_n),
		.done    (accept && done),
		.total   (total_q),
		.ms_now  (ms_next),
		.interval(interval_q),
		.value   (value_w)
	);

	assign value_ext = 32'(value_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_BLEED;
			bleed_cnt_q   <= '0;
			sense_idx_q   <= '0;
			total_q       <= '0;
			ms_q          <= '0;
			phase_start_q <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			bleed_cnt_q   <= bleed_cnt_d;
			sense_idx_q   <= sense_idx_d;
			total_q       <= total_d;
			ms_q          <= ms_next;
			phase_start_q <= phase_start_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_error_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reading_error |-> out_data.reading_valid)
		else $error("error beat without reading_valid");
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!out_data.reading_valid || out_data.reading_error)
		|-> out_data.reading_value == '0)
		else $error("nonzero value on a beat without a good reading");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted beat produced no result");
`endif

endmodule
